// ===== hw/rtl/b38_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b38_pkg: shared types and constants for the base-38 byte encoder
// Holds the group descriptor passed from the packer to the digit unit, the
// reciprocal used for the divide by 38, and the character alphabet.
// ----------------------------------------------------------------------------
package b38_pkg;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 24;
    localparam int PEND_W      = 16;
    localparam int NCHARS_W    = 3;
    localparam int DIGIT_W     = 6;

    // floor(v / 38) == (v * RECIP) >> RECIP_SHIFT for every v below 2**24.
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 30;
    localparam int PROD_W      = VALUE_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = 25'd28256364;

    localparam logic [NCHARS_W-1:0] CHARS_FULL = 3'd5;
    localparam logic [NCHARS_W-1:0] CHARS_ONE  = 3'd2;
    localparam logic [NCHARS_W-1:0] CHARS_TWO  = 3'd4;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [NCHARS_W-1:0] nchars;
        logic                last;
    } b38_job_t;

    function automatic logic [BYTE_W-1:0] b38_char(input logic [DIGIT_W-1:0] digit);
        logic [BYTE_W-1:0] c;
        begin
            unique case (digit)
                6'd0:  c = "0";
                6'd1:  c = "1";
                6'd2:  c = "2";
                6'd3:  c = "3";
                6'd4:  c = "4";
                6'd5:  c = "5";
                6'd6:  c = "6";
                6'd7:  c = "7";
                6'd8:  c = "8";
                6'd9:  c = "9";
                6'd10: c = "A";
                6'd11: c = "B";
                6'd12: c = "C";
                6'd13: c = "D";
                6'd14: c = "E";
                6'd15: c = "F";
                6'd16: c = "G";
                6'd17: c = "H";
                6'd18: c = "I";
                6'd19: c = "J";
                6'd20: c = "K";
                6'd21: c = "L";
                6'd22: c = "M";
                6'd23: c = "N";
                6'd24: c = "O";
                6'd25: c = "P";
                6'd26: c = "Q";
                6'd27: c = "R";
                6'd28: c = "S";
                6'd29: c = "T";
                6'd30: c = "U";
                6'd31: c = "V";
                6'd32: c = "W";
                6'd33: c = "X";
                6'd34: c = "Y";
                6'd35: c = "Z";
                6'd36: c = "-";
                6'd37: c = ".";
                default: c = "0";
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/base38_byte_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base38_byte_encoder_core: base-38 encoder for a byte stream
// Packs bytes into groups of three and emits each group as base-38 text.
// ----------------------------------------------------------------------------
// Bytes are packed little-endian into groups of three; each full group comes
// out as five characters of 0-9, A-Z, '-' and '.', least significant digit
// first, and a group flushed by last_byte gives two characters (one byte) or
// four (two bytes). The digit unit makes one character per cycle while the
// output register is empty or popped, and loads the next group as the last
// character of a group leaves. A completing byte passes the job queue and the
// digit unit's group registers before its first character is registered at
// the output. A two-group queue sits between packer and digit unit, and full
// rises only while it holds two groups. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module base38_byte_encoder_core
    import b38_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] out_char,
    output logic              group_end,
    output logic              message_end
);

    b38_job_t front_job;
    b38_job_t head_job;
    logic     job_push;
    logic     job_full;
    logic     job_valid;
    logic     job_pop;
    logic     back_step;

    b38_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (job_full),
        .push_job  (job_push),
        .job       (front_job)
    );

    b38_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (front_job),
        .full     (job_full),
        .rd_en    (job_pop),
        .rd_valid (job_valid),
        .rd_job   (head_job)
    );

    b38_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .step        (back_step),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .group_end   (group_end),
        .message_end (message_end)
    );

    assign full = job_full;

`ifndef SYNTHESIS
    a_msg_end_closes_group: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && message_end) |-> group_end)
        else $error("message_end seen on a beat without group_end");

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("group written into a full job queue");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        back_step |=> !empty)
        else $error("digit step did not leave a beat in the output register");

    a_pop_needs_group: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("digit unit loaded a group from an empty queue");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/b38_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b38_front: byte packer
// Collects bytes little-endian into groups of three and hands a descriptor
// of each complete or flushed group to the job queue.
// ----------------------------------------------------------------------------
module b38_front
    import b38_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    input  logic              q_full,
    output logic              push_job,
    output b38_job_t          job
);

    logic [PEND_W-1:0]  pending_bytes_reg;
    logic [1:0]         pending_count_reg;
    logic [VALUE_W-1:0] packed_value;
    logic               accept;
    logic               completes;

    assign accept = push && !q_full;

    always_comb
    begin
        unique case (pending_count_reg)
            2'd0:    packed_value = {16'b0, data_byte};
            2'd1:    packed_value = {8'b0, data_byte, 8'b0} | {8'b0, pending_bytes_reg};
            default: packed_value = {data_byte, pending_bytes_reg};
        endcase
    end

    // A count of three never occurs; it is handled as two held bytes.
    assign completes = pending_count_reg[1];
    assign push_job  = accept && (completes || last_byte);

    always_comb
    begin
        job.value = packed_value;
        job.last  = last_byte;
        priority if (completes)
            job.nchars = CHARS_FULL;
        else if (pending_count_reg == 2'd0)
            job.nchars = CHARS_ONE;
        else
            job.nchars = CHARS_TWO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= '0;
            pending_count_reg <= '0;
        end
        else if (accept)
        begin
            if (push_job)
            begin
                pending_bytes_reg <= '0;
                pending_count_reg <= '0;
            end
            else
            begin
                pending_bytes_reg <= packed_value[PEND_W-1:0];
                pending_count_reg <= pending_count_reg + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/b38_jobq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b38_jobq: two-entry group queue
// Decouples the byte packer from the digit unit so each can stall alone.
// ----------------------------------------------------------------------------
module b38_jobq
    import b38_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  b38_job_t wr_job,
    output logic     full,
    input  logic     rd_en,
    output logic     rd_valid,
    output b38_job_t rd_job
);

    b38_job_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = count_reg[1];
    assign rd_valid = count_reg != 2'd0;
    assign rd_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/b38_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b38_back: digit unit and output register
// Takes one group at a time; while the output register is empty or popped it
// divides the value by 38 and writes one alphabet character into it per cycle.
// ----------------------------------------------------------------------------
module b38_back
    import b38_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  b38_job_t          job,
    output logic              job_pop,
    output logic              step,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] out_char,
    output logic              group_end,
    output logic              message_end
);

    logic [VALUE_W-1:0]  value_reg;
    logic [NCHARS_W-1:0] left_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_char_reg;
    logic                group_end_reg;
    logic                message_end_reg;

    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot;
    logic [VALUE_W-1:0]  quot_ext;
    logic [VALUE_W-1:0]  quot38;
    logic [VALUE_W-1:0]  remainder;
    logic                busy;
    logic                out_ready;
    logic                finishing;
    logic                load;

    assign busy      = left_reg != '0;
    assign out_ready = !out_valid_reg || pop;
    assign step      = busy && out_ready;
    assign finishing = step && (left_reg == 3'd1);
    // The next group is loaded in the same cycle the last character leaves.
    assign load      = job_valid && (!busy || finishing);
    assign job_pop   = load;

    assign prod      = value_reg * RECIP;
    assign quot      = prod[PROD_W-1:RECIP_SHIFT];
    assign quot_ext  = VALUE_W'(quot);
    assign quot38    = (quot_ext << 5) + (quot_ext << 2) + (quot_ext << 1);
    assign remainder = value_reg - quot38;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                left_reg <= job.nchars;
            end
            else if (step)
            begin
                left_reg <= left_reg - 3'd1;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= job.value;
            last_reg  <= job.last;
        end
        else if (step)
        begin
            value_reg <= quot_ext;
        end

        if (step)
        begin
            out_char_reg    <= b38_char(remainder[DIGIT_W-1:0]);
            group_end_reg   <= left_reg == 3'd1;
            message_end_reg <= (left_reg == 3'd1) && last_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_char    = out_char_reg;
    assign group_end   = group_end_reg;
    assign message_end = message_end_reg;

endmodule
`default_nettype wire
